### hw/rtl/a85_pkg.sv
package a85_pkg;

    localparam int DIG_W       = 7;
    localparam int NUM_DIGITS  = 5;
    localparam int NUM_CELLS   = 4;
    localparam int Q_W         = 26;
    localparam int RECIP_SHIFT = 38;

    localparam logic [31:0]      RECIP     = 32'd3233857729;
    localparam logic [31:0]      RADIX     = 32'd85;
    localparam logic [DIG_W-1:0] OFFSET    = 7'd33;
    localparam logic [DIG_W-1:0] ZERO_CHAR = 7'd122;
    localparam logic [1:0]       HELD_FULL = 2'd3;

    typedef logic [DIG_W-1:0] dig_t;

    // one group moving down the divider chain
    typedef struct packed {
        logic                       valid;
        logic [31:0]                value;
        logic [NUM_DIGITS-1:0][DIG_W-1:0] digs;
        logic [2:0]                 nchar;
        logic                       zero;
        logic                       eos;
    } cell_item_t;

endpackage

### hw/rtl/a85_if.sv
interface a85_in_if;
    import a85_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface a85_out_if;
    import a85_pkg::*;
    logic       valid;
    logic       ready;
    dig_t       out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink (input valid, input out_char, input last_char, output ready);
endinterface

### hw/rtl/a85_cell.sv
module a85_cell
    import a85_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  cell_item_t cell_in,
    output cell_item_t cell_out
);

    typedef struct packed {
        logic [Q_W-1:0]             q;
        dig_t                       lo;
        logic [NUM_DIGITS-1:0][DIG_W-1:0] digs;
        logic [2:0]                 nchar;
        logic                       zero;
        logic                       eos;
    } mid_t;

    logic        mid_valid_reg;
    mid_t        mid_reg;
    mid_t        mid_next;
    logic [63:0] prod;
    logic [31:0] q85;
    dig_t        rem;
    logic        out_valid_reg;
    cell_item_t  out_reg;
    cell_item_t  out_next;

    // quotient by 85 through the reciprocal, exact for any 32-bit value
    assign prod = 64'(cell_in.value) * 64'(RECIP);

    always_comb
    begin
        mid_next.q     = prod[RECIP_SHIFT +: Q_W];
        mid_next.lo    = cell_in.value[DIG_W-1:0];
        mid_next.digs  = cell_in.digs;
        mid_next.nchar = cell_in.nchar;
        mid_next.zero  = cell_in.zero;
        mid_next.eos   = cell_in.eos;
    end

    // remainder is below 128, so the low bits are enough
    assign q85 = 32'(mid_reg.q) * RADIX;
    assign rem = mid_reg.lo - q85[DIG_W-1:0];

    always_comb
    begin
        out_next.valid = mid_valid_reg;
        out_next.value = 32'(mid_reg.q);
        out_next.digs  = {rem, mid_reg.digs[NUM_DIGITS-1:1]};
        out_next.nchar = mid_reg.nchar;
        out_next.zero  = mid_reg.zero;
        out_next.eos   = mid_reg.eos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mid_valid_reg <= cell_in.valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg <= mid_next;
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        cell_out       = out_reg;
        cell_out.valid = out_valid_reg;
    end

endmodule

### hw/rtl/a85_ser.sv
module a85_ser
    import a85_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_item_t grp,
    output logic       load_ok,
    a85_out_if.source  char_ch
);

    logic [2:0]                        cnt_reg;
    logic [2:0]                        cnt_next;
    logic [NUM_DIGITS-1:0][DIG_W-1:0]  chars_reg;
    logic [NUM_DIGITS-1:0][DIG_W-1:0]  chars_next;
    logic                              eos_reg;
    logic                              eos_next;
    logic                              taken;
    logic                              load;

    assign taken   = char_ch.valid && char_ch.ready;
    assign load_ok = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && taken);
    assign load    = grp.valid && load_ok;

    always_comb
    begin
        cnt_next   = cnt_reg;
        chars_next = chars_reg;
        eos_next   = eos_reg;
        if (load)
        begin
            cnt_next      = grp.nchar;
            eos_next      = grp.eos;
            chars_next[0] = grp.zero ? ZERO_CHAR : (grp.value[DIG_W-1:0] + OFFSET);
            chars_next[1] = grp.digs[4] + OFFSET;
            chars_next[2] = grp.digs[3] + OFFSET;
            chars_next[3] = grp.digs[2] + OFFSET;
            chars_next[4] = grp.digs[1] + OFFSET;
        end
        else if (taken)
        begin
            cnt_next   = cnt_reg - 3'd1;
            chars_next = {DIG_W'(0), chars_reg[NUM_DIGITS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
        eos_reg   <= eos_next;
    end

    assign char_ch.valid     = (cnt_reg != 3'd0);
    assign char_ch.out_char  = chars_reg[0];
    assign char_ch.last_char = eos_reg && (cnt_reg == 3'd1);

endmodule

### hw/rtl/ascii85_stream_encoder_core.sv
// ASCII85 encoder: takes one byte a cycle while ready, packs bytes into big-endian
// groups of four; each full group leaves as five characters ('!'..'u') or a
// single 'z' for an all-zero group, and a stream ending on n bytes (1 to 3)
// gives n+1 characters. last_char marks the final character of the stream.
// Groups go through a chain of four divide-by-85 cells, two register stages
// each, then the serializer. Bytes are taken one per cycle unless the chain
// stalls; characters leave one per cycle while char_ch is ready, so a steady
// stream is paced by the output port, five characters for four bytes.
module ascii85_stream_encoder_core
    import a85_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    a85_in_if.sink   data_ch,
    a85_out_if.source char_ch
);

    logic [23:0]  grp_reg;
    logic [23:0]  grp_next;
    logic [1:0]   held_reg;
    logic [1:0]   held_next;
    logic         advance;
    logic         accept;
    logic [31:0]  acc;
    logic         emit;
    cell_item_t   head;
    cell_item_t   chain [NUM_CELLS+1];
    logic         load_ok;

    assign acc    = {grp_reg, data_ch.data_byte};
    assign emit   = (held_reg == HELD_FULL) || data_ch.end_of_stream;
    assign accept = data_ch.valid && data_ch.ready;

    // the whole chain moves unless the tail group cannot be handed over
    assign advance       = !chain[NUM_CELLS].valid || load_ok;
    assign data_ch.ready = advance;

    always_comb
    begin
        head.valid = accept && emit;
        head.eos   = data_ch.end_of_stream;
        head.digs  = '0;
        head.zero  = 1'b0;
        case (held_reg)
            2'd0:
            begin
                head.value = {data_ch.data_byte, 24'd0};
                head.nchar = 3'd2;
            end
            2'd1:
            begin
                head.value = {grp_reg[7:0], data_ch.data_byte, 16'd0};
                head.nchar = 3'd3;
            end
            2'd2:
            begin
                head.value = {grp_reg[15:0], data_ch.data_byte, 8'd0};
                head.nchar = 3'd4;
            end
            default:
            begin
                head.value = acc;
                head.zero  = (acc == 32'd0);
                head.nchar = (acc == 32'd0) ? 3'd1 : 3'd5;
            end
        endcase
    end

    always_comb
    begin
        grp_next  = grp_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (emit)
            begin
                grp_next  = 24'd0;
                held_next = 2'd0;
            end
            else
            begin
                grp_next  = acc[23:0];
                held_next = held_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg  <= 24'd0;
            held_reg <= 2'd0;
        end
        else
        begin
            grp_reg  <= grp_next;
            held_reg <= held_next;
        end
    end

    assign chain[0] = head;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        a85_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (advance),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    a85_ser u_ser (
        .clk     (clk),
        .rst_n   (rst_n),
        .grp     (chain[NUM_CELLS]),
        .load_ok (load_ok),
        .char_ch (char_ch)
    );

endmodule
